// ===== rtl/core/mtk_pkg.sv =====
// mtk_pkg: shared constants, types and the preamble table of the morse telemetry keyer
// used by mtk_div10, mtk_keygen and morse_telemetry_keyer_top; depends on nothing

package mtk_pkg;

   // keying byte codes
   localparam logic [7:0] KEY_DOT  = 8'h0F;
   localparam logic [7:0] KEY_DASH = 8'hFF;
   localparam logic [7:0] KEY_GAP  = 8'h00;

   // value range and digit base
   localparam logic [6:0] VALUE_LIMIT = 7'd100;
   localparam logic [6:0] DIGIT_BASE  = 7'd10;
   localparam logic [3:0] DIGIT_MAX   = 4'd9;

   // run lengths
   localparam logic [5:0] HDR_LEN         = 6'd42;
   localparam logic [5:0] LEAD_GAPS       = 6'd4;
   localparam logic [5:0] TRAIL_GAPS      = 6'd2;
   localparam logic [5:0] TRAIL_GAPS_LAST = 6'd3;
   localparam logic [2:0] ELEM_GAP        = 3'd5;

   // command codes
   localparam logic CMD_HEADER = 1'b0;
   localparam logic CMD_GROUP  = 1'b1;

   // job handed from the front end to the byte sequencer
   typedef struct packed {
      logic       cmd;
      logic       ch_ok;
      logic [3:0] ch;
      logic [3:0] tens;
      logic [3:0] units;
      logic       first;
      logic       last_group;
      logic       bad;
   } mtk_job_type;

   // preamble "cq hi hi" with its gaps, one keying byte per index
   function automatic logic [7:0] mtk_hdr_byte(input logic [5:0] idx);
      logic [7:0] b;
      b = KEY_GAP;
      case (idx)
         6'd4, 6'd7, 6'd11, 6'd13, 6'd16: b = KEY_DASH;
         6'd5, 6'd6, 6'd8, 6'd9, 6'd12, 6'd14, 6'd15, 6'd17,
         6'd21, 6'd22, 6'd23, 6'd24, 6'd26, 6'd27,
         6'd31, 6'd32, 6'd33, 6'd34, 6'd36, 6'd37: b = KEY_DOT;
         default: b = KEY_GAP;
      endcase
      return b;
   endfunction

endpackage

// ===== rtl/core/mtk_div10.sv =====
// mtk_div10: splits a value below 100 into tens and units by repeated subtract of ten
// uses mtk_pkg; one compare and subtract per cycle

module mtk_div10
   import mtk_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [6:0] value,
   output logic       done,
   output logic [3:0] tens,
   output logic [3:0] units
);

   logic       busy_ff, busy_in;
   logic [6:0] rem_ff, rem_in;
   logic [3:0] quo_ff, quo_in;
   logic       below;

   // shared compare and subtract step
   assign below = (rem_ff < DIGIT_BASE);
   assign done  = busy_ff & below;
   assign tens  = quo_ff;
   assign units = rem_ff[3:0];

   always_comb begin
      busy_in = busy_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         rem_in  = value;
         quo_in  = 4'd0;
      end else if (busy_ff) begin
         if (below) begin
            busy_in = 1'b0;
         end else begin
            rem_in = rem_ff - DIGIT_BASE;
            quo_in = quo_ff + 4'd1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   // working value
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

endmodule

// ===== rtl/core/mtk_keygen.sv =====
// mtk_keygen: sequencer that walks the phases of a job and emits one keying byte per cycle
// while the output register is free; uses mtk_pkg; holds the response output register

module mtk_keygen
   import mtk_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  mtk_job_type job,
   output logic        busy,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] key_byte
   output logic        rsp_tlast,
   output logic        rsp_tuser    // [0] bad_digit
);

   typedef enum logic [6:0] {
      PH_IDLE  = 7'b0000001,
      PH_LEAD  = 7'b0000010,
      PH_CH    = 7'b0000100,
      PH_TENS  = 7'b0001000,
      PH_UNITS = 7'b0010000,
      PH_TRAIL = 7'b0100000,
      PH_HDR   = 7'b1000000
   } phase_type;

   phase_type   phase_ff, phase_in;
   mtk_job_type job_ff, job_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [2:0]  elem_ff, elem_in;
   logic        half_ff, half_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic        bad_ff, bad_in;

   logic        out_free;
   logic        emit;
   logic        key_last;
   logic [7:0]  key_byte;
   logic [3:0]  cur_digit;
   logic        dig_dash;
   logic        dig_done;
   logic [7:0]  dig_byte;
   logic [2:0]  dig_elem;
   logic        dig_half;
   logic [5:0]  trail_len;

   // element i of a morse digit is a dash or a dot
   function automatic logic is_dash(input logic [3:0] d, input logic [2:0] i);
      logic [3:0] e;
      logic       r;
      e = (d == 4'd0) ? 4'd10 : d;
      if ((d >= 4'd1) && (d <= 4'd5)) begin
         r = ({1'b0, i} >= d);
      end else begin
         r = (({1'b0, i} + 4'd5) < e);
      end
      return r;
   endfunction

   assign out_free  = ~valid_ff | rsp_tready;
   assign busy      = (phase_ff != PH_IDLE);
   assign trail_len = job_ff.last_group ? TRAIL_GAPS_LAST : TRAIL_GAPS;

   // digit under way
   always_comb begin
      unique case (phase_ff)
         PH_CH:    cur_digit = job_ff.ch;
         PH_TENS:  cur_digit = job_ff.tens;
         PH_UNITS: cur_digit = job_ff.units;
         default:  cur_digit = 4'd0;
      endcase
   end

   // one step through a digit: elements, dash halves, closing gap
   always_comb begin
      dig_dash = is_dash(cur_digit, elem_ff);
      dig_done = 1'b0;
      dig_elem = elem_ff;
      dig_half = half_ff;
      if (elem_ff == ELEM_GAP) begin
         dig_byte = KEY_GAP;
         dig_done = 1'b1;
         dig_elem = 3'd0;
         dig_half = 1'b0;
      end else if (dig_dash && !half_ff) begin
         dig_byte = KEY_DASH;
         dig_half = 1'b1;
      end else begin
         dig_byte = KEY_DOT;
         dig_half = 1'b0;
         dig_elem = elem_ff + 3'd1;
      end
   end

   // phase sequencer
   always_comb begin
      phase_in = phase_ff;
      job_in   = job_ff;
      cnt_in   = cnt_ff;
      elem_in  = elem_ff;
      half_in  = half_ff;
      emit     = 1'b0;
      key_last = 1'b0;
      key_byte = KEY_GAP;
      unique case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               job_in  = job;
               cnt_in  = 6'd0;
               elem_in = 3'd0;
               half_in = 1'b0;
               if (job.cmd == CMD_HEADER) begin
                  phase_in = PH_HDR;
               end else if (job.first) begin
                  phase_in = PH_LEAD;
               end else if (job.ch_ok) begin
                  phase_in = PH_CH;
               end else begin
                  phase_in = PH_TENS;
               end
            end
         end
         PH_LEAD: begin
            if (out_free) begin
               emit = 1'b1;
               if (cnt_ff == LEAD_GAPS - 6'd1) begin
                  cnt_in   = 6'd0;
                  phase_in = job_ff.ch_ok ? PH_CH : PH_TENS;
               end else begin
                  cnt_in = cnt_ff + 6'd1;
               end
            end
         end
         PH_CH, PH_TENS, PH_UNITS: begin
            key_byte = dig_byte;
            if (out_free) begin
               emit    = 1'b1;
               elem_in = dig_elem;
               half_in = dig_half;
               if (dig_done) begin
                  if (phase_ff == PH_CH) begin
                     phase_in = PH_TENS;
                  end else if (phase_ff == PH_TENS) begin
                     phase_in = PH_UNITS;
                  end else begin
                     phase_in = PH_TRAIL;
                  end
               end
            end
         end
         PH_TRAIL: begin
            if (out_free) begin
               emit = 1'b1;
               if (cnt_ff == trail_len - 6'd1) begin
                  key_last = 1'b1;
                  cnt_in   = 6'd0;
                  phase_in = PH_IDLE;
               end else begin
                  cnt_in = cnt_ff + 6'd1;
               end
            end
         end
         PH_HDR: begin
            key_byte = mtk_hdr_byte(cnt_ff);
            if (out_free) begin
               emit = 1'b1;
               if (cnt_ff == HDR_LEN - 6'd1) begin
                  key_last = 1'b1;
                  cnt_in   = 6'd0;
                  phase_in = PH_IDLE;
               end else begin
                  cnt_in = cnt_ff + 6'd1;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      bad_in   = bad_ff;
      if (emit) begin
         valid_in = 1'b1;
         byte_in  = key_byte;
         last_in  = key_last;
         bad_in   = job_ff.bad;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cnt_ff   <= 6'd0;
         elem_ff  <= 3'd0;
         half_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         elem_ff  <= elem_in;
         half_ff  <= half_in;
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
      bad_ff  <= bad_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = bad_ff;

endmodule

// ===== rtl/core/morse_telemetry_keyer_top.sv =====
// Morse telemetry keyer: each request becomes a run of keying bytes (0x0F dot or dash tail,
// 0xFF dash head, 0x00 gap). A header request (tuser 0) gives the 42-byte "cq hi hi"
// preamble; a group request (tuser 1) gives the channel digit and the two value digits,
// each a five-element digit plus a gap, then two trailing gaps (three when tlast is set),
// with four leading gaps when first_group is set; 14 to 40 bytes. A channel above 9 is
// dropped and a value of 100 or more is sent as 00, both flagged on rsp_tuser; rsp_tlast
// marks the final byte of a request. Each request passes through the subtract-by-ten digit
// splitter and then the sequencer, which issues its bytes in order and holds a byte while
// rsp_tready is low. The next request is taken only after the sequencer has issued the
// last byte of the previous one.
// depends on mtk_pkg, mtk_div10 and mtk_keygen

module morse_telemetry_keyer_top
   import mtk_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [3:0] channel, [10:4] value, [11] first_group, 0 above
   input  logic        req_tlast,   // last_group
   input  logic        req_tuser,   // [0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] key_byte
   output logic        rsp_tlast,   // last
   output logic        rsp_tuser    // [0] bad_digit
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type   state_ff, state_in;
   logic        cmd_ff;
   logic [3:0]  ch_ff;
   logic        first_ff;
   logic        lastg_ff;
   logic        bad_ff;

   logic        accept;
   logic [3:0]  in_ch;
   logic [6:0]  in_value;
   logic        ch_bad;
   logic        val_bad;
   logic [6:0]  div_value;
   logic        div_done;
   logic [3:0]  div_tens;
   logic [3:0]  div_units;
   logic        kg_start;
   logic        kg_busy;
   mtk_job_type job;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign in_ch      = req_tdata[3:0];
   assign in_value   = req_tdata[10:4];
   assign ch_bad     = (in_ch > DIGIT_MAX);
   assign val_bad    = (in_value >= VALUE_LIMIT);
   assign div_value  = (val_bad || (req_tuser == CMD_HEADER)) ? 7'd0 : in_value;

   // request fields
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_tuser;
         ch_ff    <= in_ch;
         first_ff <= req_tdata[11];
         lastg_ff <= req_tlast;
         bad_ff   <= (req_tuser == CMD_GROUP) & (ch_bad | val_bad);
      end
   end

   // front-end control
   always_comb begin
      state_in = state_ff;
      kg_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               kg_start = 1'b1;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!kg_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // job for the sequencer
   always_comb begin
      job.cmd        = cmd_ff;
      job.ch_ok      = (ch_ff <= DIGIT_MAX);
      job.ch         = ch_ff;
      job.tens       = div_tens;
      job.units      = div_units;
      job.first      = first_ff;
      job.last_group = lastg_ff;
      job.bad        = bad_ff;
   end

   mtk_div10 u_div10 (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .value (div_value),
      .done  (div_done),
      .tens  (div_tens),
      .units (div_units)
   );

   mtk_keygen u_keygen (
      .clock      (clock),
      .reset      (reset),
      .start      (kg_start),
      .job        (job),
      .busy       (kg_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== dv/mtk_keying_checker.sv =====
`timescale 1ns / 1ps
// mtk_keying_checker: watches the request and response streams of the keyer, works out the
// keying bytes of every accepted request and compares them with the response stream in order
// depends on mtk_pkg for the key codes and the command codes

module mtk_keying_checker
   import mtk_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // [3:0] channel, [10:4] value, [11] first_group, 0 above
   input  logic        req_tlast,   // last_group
   input  logic        req_tuser,   // [0] command
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // [7:0] key_byte
   input  logic        rsp_tlast,   // last
   input  logic        rsp_tuser,   // [0] bad_digit
   output int          mismatch_count,
   output int          bytes_pending
);

   typedef struct packed {
      logic [7:0] key_byte;
      logic       last;
      logic       bad_digit;
   } key_beat_type;

   key_beat_type key_expect_q[$];
   logic [7:0]   key_run[$];
   int           mismatches = 0;
   int           pending = 0;

   assign mismatch_count = mismatches;
   assign bytes_pending  = pending;

   // element builders for one run of keying bytes
   function void add_gaps(int n);
      for (int i = 0; i < n; i++) key_run.push_back(KEY_GAP);
   endfunction

   function void add_dots(int n);
      for (int i = 0; i < n; i++) key_run.push_back(KEY_DOT);
   endfunction

   function void add_dashes(int n);
      for (int i = 0; i < n; i++) begin
         key_run.push_back(KEY_DASH);
         key_run.push_back(KEY_DOT);
      end
   endfunction

   // five-element morse digit plus its gap; 1..5 lead with dots, 6..9 and 0 with dashes
   function void add_digit(int d);
      int e;
      if (d >= 1 && d <= 5) begin
         add_dots(d);
         add_dashes(5 - d);
      end else begin
         e = (d == 0) ? 10 : d;
         add_dashes(e - 5);
         add_dots(10 - e);
      end
      add_gaps(1);
   endfunction

   // expected keying bytes of one request, appended to the expectation queue
   function void predict_keying(logic cmd, logic [3:0] ch, logic [6:0] val, logic first,
                                logic last_grp);
      logic         bad;
      int           v;
      key_beat_type beat;
      bad = 1'b0;
      key_run.delete();
      if (cmd == CMD_HEADER) begin
         // "cq hi hi" with its word gaps
         add_gaps(4);
         add_dashes(1); add_dots(1); add_dashes(1); add_dots(1); add_gaps(1);
         add_dashes(2); add_dots(1); add_dashes(1); add_gaps(3);
         add_dots(4); add_gaps(1); add_dots(2); add_gaps(3);
         add_dots(4); add_gaps(1); add_dots(2); add_gaps(4);
      end else begin
         if (first) add_gaps(4);
         // a channel out of range is dropped together with its gap
         if (ch <= 4'd9) add_digit(int'(ch));
         else bad = 1'b1;
         v = int'(val);
         // an out of range value goes out as 00
         if (v >= 100) begin
            bad = 1'b1;
            v = 0;
         end
         add_digit(v / 10);
         add_digit(v % 10);
         add_gaps(last_grp ? 3 : 2);
      end
      foreach (key_run[i]) begin
         beat.key_byte  = key_run[i];
         beat.last      = (i == key_run.size() - 1);
         beat.bad_digit = bad;
         key_expect_q.push_back(beat);
      end
   endfunction

   // compare each response byte with the oldest expectation, then take new requests
   always @(posedge clock) begin : watch
      key_beat_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (key_expect_q.size() == 0) begin
               $error("key_byte %h arrived with no request outstanding", rsp_tdata);
               mismatches++;
            end else begin
               want = key_expect_q.pop_front();
               if (rsp_tdata !== want.key_byte) begin
                  $error("key_byte: expected %h, got %h", want.key_byte, rsp_tdata);
                  mismatches++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last: expected %b, got %b", want.last, rsp_tlast);
                  mismatches++;
               end
               if (rsp_tuser !== want.bad_digit) begin
                  $error("bad_digit: expected %b, got %b", want.bad_digit, rsp_tuser);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready)
            predict_keying(req_tuser, req_tdata[3:0], req_tdata[10:4], req_tdata[11], req_tlast);
         pending = key_expect_q.size();
      end
   end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// tb: top of the keyer testbench; drives requests and response backpressure, gives the verdict
// depends on mtk_pkg, morse_telemetry_keyer_top and mtk_keying_checker

module tb;
   import mtk_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;    // [3:0] channel, [10:4] value, [11] first_group, 0 above
   logic        req_tlast = 1'b0;  // last_group
   logic        req_tuser = 1'b0;  // [0] command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // [7:0] key_byte
   logic        rsp_tlast;         // last
   logic        rsp_tuser;         // [0] bad_digit

   int   mismatch_count;
   int   bytes_pending;
   int   requests_sent = 0;
   int   bytes_taken = 0;
   logic no_idle = 1'b0;
   logic hold_done = 1'b0;

   always #6 clock = ~clock;

   morse_telemetry_keyer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   mtk_keying_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .bytes_pending  (bytes_pending)
   );

   // idle stretch: mostly short, now and then a long one
   function int idle_len();
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   // offer one request and hold it until it is taken; valid stays up when no gap follows
   task automatic send_request(logic cmd, logic [3:0] ch, logic [6:0] val, logic first,
                               logic last_grp);
      int gap;
      gap = (no_idle || $urandom_range(0, 1) == 0) ? 0 : idle_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tlast  <= last_grp;
      req_tdata  <= {4'b0000, first, val, ch};
      do @(posedge clock); while (!req_tready);
      requests_sent++;
   endtask

   // group with mostly valid digits and an occasional out of range channel or value
   task automatic send_group_random(logic first, logic last_grp);
      logic [3:0] ch;
      logic [6:0] val;
      ch  = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(10, 15))
                                        : 4'($urandom_range(0, 9));
      val = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(100, 127))
                                        : 7'($urandom_range(0, 99));
      send_request(CMD_GROUP, ch, val, first, last_grp);
   endtask

   // response backpressure, with one long hold-off that fills the block up
   initial begin : rsp_side
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_tready <= 1'b0;
         end else if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else if (!hold_done && bytes_taken >= 600) begin
            hold_done = 1'b1;
            stall = 299;
            rsp_tready <= 1'b0;
         end else if (!no_idle && $urandom_range(0, 4) == 0) begin
            stall = idle_len() - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) bytes_taken <= bytes_taken + 1;
   end

   // request stimulus and verdict
   initial begin : stimulus
      int n;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: every digit, range extremes, flags on header ignored
      send_request(CMD_HEADER, 4'd0, 7'd0, 1'b0, 1'b0);
      send_request(CMD_HEADER, 4'd15, 7'd127, 1'b1, 1'b1);
      send_request(CMD_GROUP, 4'd0, 7'd0, 1'b0, 1'b0);
      send_request(CMD_GROUP, 4'd9, 7'd99, 1'b1, 1'b1);
      send_request(CMD_GROUP, 4'd1, 7'd23, 1'b1, 1'b0);
      send_request(CMD_GROUP, 4'd4, 7'd56, 1'b0, 1'b1);
      send_request(CMD_GROUP, 4'd7, 7'd89, 1'b0, 1'b0);
      send_request(CMD_GROUP, 4'd8, 7'd10, 1'b1, 1'b1);
      // channel out of range
      send_request(CMD_GROUP, 4'd10, 7'd45, 1'b0, 1'b0);
      send_request(CMD_GROUP, 4'd15, 7'd67, 1'b1, 1'b1);
      // value out of range
      send_request(CMD_GROUP, 4'd3, 7'd100, 1'b0, 1'b1);
      send_request(CMD_GROUP, 4'd6, 7'd127, 1'b1, 1'b0);
      // both out of range
      send_request(CMD_GROUP, 4'd12, 7'd115, 1'b1, 1'b1);
      send_request(CMD_GROUP, 4'd2, 7'd64, 1'b0, 1'b0);
      send_request(CMD_GROUP, 4'd5, 7'd5, 1'b0, 1'b0);

      // random frames: header then a run of groups, with some stray requests between
      while (requests_sent < 210) begin
         no_idle = (requests_sent >= 120 && requests_sent < 150);
         if ($urandom_range(0, 4) == 0) begin
            send_request(1'($urandom_range(0, 1)), 4'($urandom), 7'($urandom),
                         1'($urandom), 1'($urandom));
         end else begin
            n = $urandom_range(1, 6);
            send_request(CMD_HEADER, 4'($urandom), 7'($urandom), 1'($urandom), 1'($urandom));
            for (int i = 0; i < n; i++) send_group_random(i == 0, i == n - 1);
         end
      end
      no_idle = 1'b0;
      req_tvalid <= 1'b0;

      // drain, then give the block time to show any stray bytes
      @(negedge clock);
      wait (bytes_pending == 0);
      repeat (60) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

   initial begin : watchdog
      #15_000_000;
      $display("tb failed");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/mtk_pkg.sv
rtl/core/mtk_div10.sv
rtl/core/mtk_keygen.sv
rtl/core/morse_telemetry_keyer_top.sv
dv/mtk_keying_checker.sv
dv/tb.sv
